// ===== design/mcbwa_pkg.sv =====
// Package for the multichannel block and window averager.
// Holds the fixed field widths, register map sizes and parameter defaults.
// No dependencies; the top level refers to it by scoped names.

package mcbwa_pkg;

    // Fixed field widths of the ports.
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 12;
    localparam int LEN_CFG_W = 7;
    localparam int CFG_IDX_W = 3;

    // Register map: one window length register per channel.
    localparam int NUM_REGS  = 5;
    localparam int LEN_RESET = 16;

    // Parameter defaults for the top level.
    localparam int DEF_MAX_WINDOW   = 64;
    localparam int DEF_NUM_CHANNELS = 5;
    localparam int DEF_BLOCK_SIZE   = 16;

endpackage

// ===== design/multichannel_block_and_window_average.sv =====
// Multichannel block and window averager: top level with the sequencer.
// Uses mcbwa_pkg, mcbwa_ram (accumulator and ring stores) and mcbwa_div.

// Each channel sums BLOCK_SIZE samples. On the closing sample the block mean
// enters that channel's ring window, and one result carries the block mean and
// the window mean (window sum / window length, truncated). A sample that does
// not close a block is accepted, and then the accumulator memory is read and
// written back. A closing sample goes through these steps in order:
// - accept it;
// - form the block mean by a constant reciprocal multiply (a plain shift
//   when BLOCK_SIZE is a power of two);
// - do the ring store read-modify-write;
// - run the serial divider for the window mean;
// - see the divider finish;
// - load the output register.
// A result that is held off keeps the sequencer in its output state, which
// stalls the sample channel until the result transfer completes. No clearing
// pass is needed after reset or after a length write: a per-channel wrap flag
// masks ring entries not yet written since the last clear. Length writes are
// taken only while the sequencer is idle, and a pending length write holds off
// sample transfers.

module multichannel_block_and_window_average #(
    parameter int MAX_WINDOW   = mcbwa_pkg::DEF_MAX_WINDOW,
    parameter int NUM_CHANNELS = mcbwa_pkg::DEF_NUM_CHANNELS,
    parameter int BLOCK_SIZE   = mcbwa_pkg::DEF_BLOCK_SIZE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Sample channel
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [mcbwa_pkg::CHAN_W-1:0]     chan,
    input  logic [mcbwa_pkg::SAMPLE_W-1:0]   sample,
    // Result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [mcbwa_pkg::CHAN_W-1:0]     out_chan,
    output logic [mcbwa_pkg::SAMPLE_W-1:0]   block_mean,
    output logic [mcbwa_pkg::SAMPLE_W-1:0]   window_mean,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcbwa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcbwa_pkg::LEN_CFG_W-1:0]  cfg_data
);

    localparam int SAMPLE_W   = mcbwa_pkg::SAMPLE_W;
    localparam int CHAN_W     = mcbwa_pkg::CHAN_W;
    localparam int CFG_IDX_W  = mcbwa_pkg::CFG_IDX_W;
    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W      = $clog2(BLOCK_SIZE);
    localparam int ACC_W      = SAMPLE_W + CNT_W;
    localparam int SUM_W      = SAMPLE_W + POS_W;
    localparam int DVD_W      = SUM_W;
    localparam int DVS_W      = LEN_W;
    localparam int RING_DEPTH = NUM_CHANNELS * MAX_WINDOW;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_INIT   = (mcbwa_pkg::LEN_RESET > MAX_WINDOW) ?
                                MAX_WINDOW : mcbwa_pkg::LEN_RESET;

    // Block mean by reciprocal multiplication, exact for every ACC_W-bit sum.
    localparam int     BM_SHIFT = ACC_W + CNT_W;
    localparam int     RCP_W    = ACC_W + 1;
    localparam int     PROD_W   = ACC_W + RCP_W;
    localparam longint BM_RECIP = ((longint'(1) << BM_SHIFT) + longint'(BLOCK_SIZE) - 1)
                                  / longint'(BLOCK_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_RING,
        S_WDIV,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CH_IDX_W-1:0]   ch_reg, ch_next;
    logic [SAMPLE_W-1:0]   samp_reg, samp_next;
    logic [SAMPLE_W-1:0]   bmean_reg, bmean_next;

    // Per-channel window control state.
    logic [LEN_W-1:0]      len_reg  [NUM_CHANNELS];
    logic [LEN_W-1:0]      len_next [NUM_CHANNELS];
    logic [POS_W-1:0]      pos_reg  [NUM_CHANNELS];
    logic [POS_W-1:0]      pos_next [NUM_CHANNELS];
    logic [SUM_W-1:0]      sum_reg  [NUM_CHANNELS];
    logic [SUM_W-1:0]      sum_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] wrap_reg, wrap_next;
    logic [NUM_CHANNELS-1:0] accv_reg, accv_next;

    // Output register.
    logic                  result_valid_reg, result_valid_next;
    logic [CHAN_W-1:0]     out_chan_reg, out_chan_next;
    logic [SAMPLE_W-1:0]   block_mean_reg, block_mean_next;
    logic [SAMPLE_W-1:0]   window_mean_reg, window_mean_next;

    // Memory and divider hookup.
    logic                  acc_we, acc_re;
    logic [CH_IDX_W-1:0]   acc_raddr;
    logic [ACC_W+CNT_W-1:0] acc_wdata, acc_rdata;
    logic                  ring_we, ring_re;
    logic [RING_AW-1:0]    ring_addr;
    logic [SAMPLE_W-1:0]   ring_wdata, ring_rdata;
    logic                  div_start, div_done;
    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic [SAMPLE_W-1:0]   div_quo;

    // Handshake and decode.
    logic                  sample_xfer, chan_ok;
    logic                  cfg_xfer, cfg_hit;
    logic [LEN_W-1:0]      cfg_len;
    logic [ACC_W-1:0]      cur_acc, new_acc;
    logic [CNT_W-1:0]      cur_cnt;
    logic                  block_last;
    logic [PROD_W-1:0]     bm_prod;
    logic [SAMPLE_W-1:0]   bm_quot;
    logic [SAMPLE_W-1:0]   old_entry;
    logic [SUM_W-1:0]      new_sum;
    logic [LEN_W-1:0]      pos_inc;
    logic                  pos_wrap;

    assign sample_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready    = (state_reg == S_IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign chan_ok      = ({1'b0, chan} < (CHAN_W + 1)'(NUM_CHANNELS));
    assign cfg_xfer     = cfg_valid && cfg_ready;
    assign cfg_hit      = cfg_xfer
                          && ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(mcbwa_pkg::NUM_REGS))
                          && ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(NUM_CHANNELS));

    // Clamp a written length into 1 .. MAX_WINDOW.
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if ({1'b0, cfg_data} > 8'(MAX_WINDOW))
        begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_len = LEN_W'(cfg_data);
        end
    end

    // Accumulator word as read back; an entry not written since reset reads zero.
    assign cur_acc    = accv_reg[ch_reg] ? acc_rdata[ACC_W+CNT_W-1:CNT_W] : '0;
    assign cur_cnt    = accv_reg[ch_reg] ? acc_rdata[CNT_W-1:0] : '0;
    assign new_acc    = cur_acc + ACC_W'(samp_reg);
    assign block_last = (cur_cnt == CNT_W'(BLOCK_SIZE - 1));

    // Block mean: the closing sum times the scaled reciprocal of BLOCK_SIZE.
    assign bm_prod    = PROD_W'(new_acc) * PROD_W'(BM_RECIP);
    assign bm_quot    = bm_prod[BM_SHIFT +: SAMPLE_W];

    // Ring slot of the current channel and the window update around it.
    assign ring_addr  = RING_AW'(ch_reg) * RING_AW'(MAX_WINDOW) + RING_AW'(pos_reg[ch_reg]);
    assign old_entry  = wrap_reg[ch_reg] ? ring_rdata : '0;
    assign new_sum    = sum_reg[ch_reg] - SUM_W'(old_entry) + SUM_W'(bmean_reg);
    assign pos_inc    = LEN_W'(pos_reg[ch_reg]) + LEN_W'(1);
    assign pos_wrap   = (pos_inc == len_reg[ch_reg]);
    assign ring_wdata = bmean_reg;

    assign acc_raddr  = chan[CH_IDX_W-1:0];
    assign acc_re     = sample_xfer && chan_ok;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        samp_next         = samp_reg;
        bmean_next        = bmean_reg;
        len_next          = len_reg;
        pos_next          = pos_reg;
        sum_next          = sum_reg;
        wrap_next         = wrap_reg;
        accv_next         = accv_reg;
        result_valid_next = result_valid_reg;
        out_chan_next     = out_chan_reg;
        block_mean_next   = block_mean_reg;
        window_mean_next  = window_mean_reg;
        acc_we            = 1'b0;
        acc_wdata         = '0;
        ring_we           = 1'b0;
        ring_re           = 1'b0;
        div_start         = 1'b0;
        div_dividend      = '0;
        div_divisor       = '0;

        // The waiting result leaves on a completed transfer.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        // A length write restarts that channel's window.
        if (cfg_hit)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    len_next[i]  = cfg_len;
                    pos_next[i]  = '0;
                    sum_next[i]  = '0;
                    wrap_next[i] = 1'b0;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_re)
                begin
                    ch_next    = chan[CH_IDX_W-1:0];
                    samp_next  = sample;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                acc_we           = 1'b1;
                accv_next[ch_reg] = 1'b1;
                if (block_last)
                begin
                    bmean_next   = bm_quot;
                    ring_re      = 1'b1;
                    state_next   = S_RING;
                end
                else
                begin
                    acc_wdata  = {new_acc, cur_cnt + CNT_W'(1)};
                    state_next = S_IDLE;
                end
            end
            S_RING:
            begin
                ring_we           = 1'b1;
                sum_next[ch_reg]  = new_sum;
                pos_next[ch_reg]  = pos_wrap ? '0 : POS_W'(pos_inc);
                if (pos_wrap)
                begin
                    wrap_next[ch_reg] = 1'b1;
                end
                div_start    = 1'b1;
                div_dividend = DVD_W'(new_sum);
                div_divisor  = DVS_W'(len_reg[ch_reg]);
                state_next   = S_WDIV;
            end
            S_WDIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    out_chan_next     = CHAN_W'(ch_reg);
                    block_mean_next   = bmean_reg;
                    window_mean_next  = div_quo;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, per-channel control and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ch_reg           <= '0;
            samp_reg         <= '0;
            bmean_reg        <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                len_reg[i] <= LEN_W'(LEN_INIT);
                pos_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            wrap_reg         <= '0;
            accv_reg         <= '0;
            result_valid_reg <= 1'b0;
            out_chan_reg     <= '0;
            block_mean_reg   <= '0;
            window_mean_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            ch_reg           <= ch_next;
            samp_reg         <= samp_next;
            bmean_reg        <= bmean_next;
            len_reg          <= len_next;
            pos_reg          <= pos_next;
            sum_reg          <= sum_next;
            wrap_reg         <= wrap_next;
            accv_reg         <= accv_next;
            result_valid_reg <= result_valid_next;
            out_chan_reg     <= out_chan_next;
            block_mean_reg   <= block_mean_next;
            window_mean_reg  <= window_mean_next;
        end
    end

    // Block accumulator store: {sum, count} per channel.
    mcbwa_ram #(
        .WIDTH (ACC_W + CNT_W),
        .DEPTH (NUM_CHANNELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (ch_reg),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Window ring store: MAX_WINDOW block means per channel.
    mcbwa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_addr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_addr),
        .rdata (ring_rdata)
    );

    // Serial divider for the window mean.
    mcbwa_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W),
        .QUO_W (SAMPLE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_valid = result_valid_reg;
    assign out_chan     = out_chan_reg;
    assign block_mean   = block_mean_reg;
    assign window_mean  = window_mean_reg;

endmodule

// ===== design/mcbwa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the block accumulator store and the window ring store.
// No package dependencies.

module mcbwa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 320
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write first in program order; a read of the same address returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/mcbwa_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in QUO_W bits.
// Depends on nothing but its parameters.

module mcbwa_div #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 7,
    parameter int QUO_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int REM_W = DVS_W + 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] dvs_ext;
    logic             fits;

    // One long-division step: shift in the next dividend bit and try a subtract.
    assign trial   = {rem_reg[REM_W-2:0], low_reg[QUO_W-1]};
    assign dvs_ext = {1'b0, dvs_reg};
    assign fits    = (trial >= dvs_ext);

    // Next-state logic. The top dividend bits are known to lie below the divisor,
    // so they seed the partial remainder directly.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = REM_W'(dividend[DVD_W-1:QUO_W]);
            low_next  = dividend[QUO_W-1:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - dvs_ext) : trial;
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
